>>> src/dar_pkg.sv
// package for the debounced auto-repeat key block
// shared widths, register indexes and item types; no dependencies

package dar_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned IdxW   = 8;

  // released level after reset (pressed level resets to 0, active low)
  localparam logic RelReset = 1'b1;

  localparam logic [CfgW-1:0] FirstDelayRst  = CfgW'(300);
  localparam logic [CfgW-1:0] RepeatDelayRst = CfgW'(100);
  localparam logic [CfgW-1:0] IdleTicksRst   = CfgW'(200);

  typedef enum logic [IdxW-1:0] {
    CfgFirstDelay   = IdxW'(0),
    CfgRepeatDelay  = IdxW'(1),
    CfgIdleTicks    = IdxW'(2),
    CfgPressedLevel = IdxW'(3)
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] first_delay;
    logic [CfgW-1:0] repeat_delay;
    logic [CfgW-1:0] idle_ticks;
    logic            pressed_level;
  } cfg_t;

  typedef struct packed {
    logic pin_level;
    logic take_event;
  } in_item_t;

  typedef struct packed {
    logic press_taken;
    logic press_pending;
    logic idle_flag;
  } out_item_t;

endpackage

>>> src/dar_cfg_regs.sv
// configuration register file for the debounced auto-repeat key
// depends on dar_pkg

module dar_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic [dar_pkg::IdxW-1:0] cfg_index_i,
  input  logic [dar_pkg::CfgW-1:0] cfg_data_i,
  output dar_pkg::cfg_t            cfg_o
);
  import dar_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_delay   <= FirstDelayRst;
      cfg_q.repeat_delay  <= RepeatDelayRst;
      cfg_q.idle_ticks    <= IdleTicksRst;
      cfg_q.pressed_level <= ~RelReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFirstDelay:   cfg_q.first_delay   <= cfg_data_i;
        CfgRepeatDelay:  cfg_q.repeat_delay  <= cfg_data_i;
        CfgIdleTicks:    cfg_q.idle_ticks    <= cfg_data_i;
        CfgPressedLevel: cfg_q.pressed_level <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> src/dar_core.sv
// debounce, auto-repeat and idle state with its one-tick update
// depends on dar_pkg

module dar_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  dar_pkg::in_item_t   item_i,
  input  dar_pkg::cfg_t       cfg_i,
  output dar_pkg::out_item_t  res_o
);
  import dar_pkg::*;

  logic [2:0]        hist_q, hist_d;
  logic              acc_q, acc_d;
  logic              pend_q, pend_d;
  logic [TimerW-1:0] hold_q, hold_d;
  logic [TimerW-1:0] reload_q, reload_d;
  logic [TimerW-1:0] idle_q, idle_d;
  logic [TimerW-1:0] idle_dec;
  logic              seen_q, seen_d;
  logic              stable, is_pr, pend_set, pend_mid, taken;

  always_comb begin
    hist_d   = {hist_q[1:0], item_i.pin_level};
    stable   = (hist_d == 3'b000) || (hist_d == 3'b111);
    is_pr    = (item_i.pin_level == cfg_i.pressed_level);
    idle_dec = (idle_q != '0) ? idle_q - TimerW'(1) : '0;
    acc_d    = acc_q;
    hold_d   = hold_q;
    reload_d = reload_q;
    idle_d   = idle_q;
    seen_d   = seen_q;
    pend_set = 1'b0;
    if (stable) begin
      if (acc_q != item_i.pin_level) begin
        acc_d = item_i.pin_level;
        if (is_pr) begin
          // new press
          pend_set = 1'b1;
          hold_d   = reload_q;
          idle_d   = TimerW'(cfg_i.idle_ticks);
          seen_d   = 1'b0;
        end
      end else if (is_pr) begin
        if (hold_q <= TimerW'(1)) begin
          // re-arm so the held key reads as a fresh press
          hold_d   = '0;
          acc_d    = ~cfg_i.pressed_level;
          reload_d = TimerW'(cfg_i.repeat_delay);
        end else begin
          hold_d = hold_q - TimerW'(1);
        end
      end else begin
        idle_d = idle_dec;
        if (idle_dec == '0) seen_d = 1'b1;
      end
      if (!is_pr) reload_d = TimerW'(cfg_i.first_delay);
    end
    pend_mid = pend_set | pend_q;
    taken    = item_i.take_event & pend_mid;
    pend_d   = pend_mid & ~item_i.take_event;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q   <= {3{RelReset}};
      acc_q    <= RelReset;
      pend_q   <= 1'b0;
      hold_q   <= TimerW'(FirstDelayRst);
      reload_q <= TimerW'(FirstDelayRst);
      idle_q   <= TimerW'(IdleTicksRst);
      seen_q   <= 1'b0;
    end else if (step_i) begin
      hist_q   <= hist_d;
      acc_q    <= acc_d;
      pend_q   <= pend_d;
      hold_q   <= hold_d;
      reload_q <= reload_d;
      idle_q   <= idle_d;
      seen_q   <= seen_d;
    end
  end

  assign res_o.press_taken   = taken;
  assign res_o.press_pending = pend_d;
  assign res_o.idle_flag     = seen_d;

  // idle flag only stands once the idle counter has run out
  a_seen_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q |-> (idle_q == '0))
    else $error("idle flag set with idle counter running");

  // pending only rises from a processed tick
  a_pend_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pend_q) |-> $past(step_i))
    else $error("pending rose without a tick");

  // state holds between ticks
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(hold_q) && $stable(idle_q) && $stable(acc_q))
    else $error("counter state moved without a tick");

endmodule

>>> src/debounce_autorepeat_key.sv
// top level of the debounced auto-repeat key with idle detection
// depends on dar_pkg, dar_cfg_regs and dar_core
// path: an accepted item passes the input stage register, then the result register
// throughput: one item per cycle; ready drops only while both stages are stalled
// reset: asynchronous active-low, registers to 300/100/200/active low,
// key state to released, no pending press, idle flag low

module debounce_autorepeat_key (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  dar_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output dar_pkg::out_item_t       out_item_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [dar_pkg::IdxW-1:0] cfg_index_i,
  input  logic [dar_pkg::CfgW-1:0] cfg_data_i
);
  import dar_pkg::*;

  cfg_t      cfg;
  in_item_t  s1_item_q;
  logic      s1_valid_q;
  out_item_t res;
  out_item_t out_item_q;
  logic      out_valid_q;
  logic      out_free, s1_adv, in_acc;

  // config writes are registered and always taken
  assign cfg_ready_o = 1'b1;

  dar_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // result slot empties or is being taken
  assign out_free   = !out_valid_q || out_ready_i;
  // the buffered item runs through the tick update
  assign s1_adv     = s1_valid_q && out_free;
  // input stage takes a new item when empty or moving on
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
  end

  dar_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a buffered item with a free result slot shows up next cycle
  a_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_q)
    else $error("processed item lost before the result register");

  // a blocked input stage keeps its item
  a_s1_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_free) |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled item dropped or changed");

  // empty input stage always takes an item
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_ready_o)
    else $error("input stalled while empty");

endmodule
